// ===== rtl/command_stream_validator_defines.svh =====
// ----------------------------------------------------------------------------
// Command stream validator assertion macros
// Concurrent checks for the validator; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef COMMAND_STREAM_VALIDATOR_DEFINES_SVH
`define COMMAND_STREAM_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("command stream validator check failed");

// Next-cycle implication
`define CSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("command stream validator check failed");

`else

`define CSV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/csv_pkg.sv =====
// ----------------------------------------------------------------------------
// Command stream validator package
// Shared constants, register and status codes, and the opcode shape table.
// ----------------------------------------------------------------------------
`default_nettype none

package csv_pkg;

	localparam int unsigned WORD_BITS       = 32;
	localparam int unsigned BV_BITS         = 3;
	localparam int unsigned CFG_INDEX_BITS  = 3;
	localparam int unsigned HEADER_BYTES    = 16;
	localparam int unsigned WORD_BYTES      = 4;

	// Header word offsets
	localparam int unsigned OFF_IDENT       = 0;
	localparam int unsigned OFF_GEOMETRY    = 4;
	localparam int unsigned OFF_COUNT       = 8;
	localparam int unsigned OFF_LENGTH      = 12;

	localparam logic [7:0] MAGIC_BYTE0      = 8'd0;
	localparam logic [7:0] MAGIC_BYTE1      = 8'd1;
	localparam logic [BV_BITS-1:0] FULL_WORD = 3'd4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CHIP_GEN          = 3'd0,
		REG_TILE_ROWS         = 3'd1,
		REG_TILE_COLUMNS      = 3'd2,
		REG_MEMORY_TILE_ROWS  = 3'd3,
		REG_FORMAT_VERSION    = 3'd4
	} csv_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_INVALID     = 2'd1,
		STATUS_UNSUPPORTED = 2'd2
	} csv_status_t;

	// Expected header geometry bytes
	typedef struct packed {
		logic [7:0] chip_gen;
		logic [7:0] tile_rows;
		logic [7:0] tile_columns;
		logic [7:0] memory_tile_rows;
	} csv_geometry_t;

	// Per-opcode minimum size and size word slot (word index, zero for none)
	typedef struct packed {
		logic [5:0] minimum;
		logic [2:0] slot;
		logic       legal;
	} csv_shape_t;

	// End-of-transaction verdict from the walker to the result stage
	typedef struct packed {
		logic valid;
		logic invalid;
	} csv_verdict_t;

	function automatic csv_shape_t opcode_shape(input logic [7:0] opc);
		csv_shape_t s;
		s.minimum = 6'd0;
		s.slot    = 3'd0;
		s.legal   = 1'b1;
		case (opc)
			8'd0: begin
				s.minimum = 6'd24;
				s.slot    = 3'd5;
			end
			8'd1: begin
				s.minimum = 6'd16;
				s.slot    = 3'd3;
			end
			8'd2: s.minimum = 6'd16;
			8'd3: begin
				s.minimum = 6'd28;
				s.slot    = 3'd6;
			end
			8'd4, 8'd7: begin
				s.minimum = 6'd32;
				s.slot    = 3'd6;
			end
			8'd5, 8'd6, 8'd13: s.minimum = 6'd4;
			8'd8, 8'd10: s.minimum = 6'd16;
			8'd9, 8'd11: s.minimum = 6'd8;
			8'd12: s.minimum = 6'd12;
			default: begin
				// Extended opcodes carry a size word right after the opcode word
				if (opc[7]) begin
					s.minimum = 6'd8;
					s.slot    = 3'd1;
				end else begin
					s.legal   = 1'b0;
				end
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/csv_in_if.sv =====
// ----------------------------------------------------------------------------
// Command word channel
// Valid/ready channel carrying one transaction word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface csv_in_if import csv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] word;
	logic                 last;
	logic [BV_BITS-1:0]   bytes_valid;

	modport source (output valid, word, last, bytes_valid, input ready);
	modport sink   (input valid, word, last, bytes_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/csv_out_if.sv =====
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel carrying one transaction status per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface csv_out_if ();
	logic       valid;
	logic       ready;
	logic [1:0] status;

	modport source (output valid, status, input ready);
	modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/csv_walk.sv =====
// ----------------------------------------------------------------------------
// Command stream walker
// Checks header words and walks operations, one word per step; raises the
// end-of-transaction verdict on the last word and clears for the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_walk import csv_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic                 last,
	input  wire logic [BV_BITS-1:0]   bytes_valid,
	input  wire csv_geometry_t        geometry,
	output csv_verdict_t              verdict
);

	localparam int unsigned LB  = LENGTH_BITS;
	localparam int unsigned LB1 = LENGTH_BITS + 1;
	localparam logic [LB:0] LEN_MAX = {1'b0, {LB{1'b1}}};

	logic [LB-1:0]        offset_q, declared_q, op_start_q, op_end_q;
	logic [WORD_BITS-1:0] ops_left_q;
	logic [5:0]           op_min_q;
	logic [2:0]           slot_q;
	logic                 in_op_q, sticky_q;

	logic [LB-1:0]        offset_d, declared_d, op_start_d, op_end_d;
	logic [WORD_BITS-1:0] ops_left_d;
	logic [5:0]           op_min_d;
	logic [2:0]           slot_d;
	logic                 in_op_d, sticky_d;

	logic [LB:0]          actual;
	logic                 overflow, partial, walk_en, walk_err;
	logic [7:0]           b0, b1, b2, b3;
	logic [LB-1:0]        rel, room, avail, size_end, start_end, end_sel;
	csv_shape_t           shape;
	logic                 slot_hit, size_bad, start_bad, len_bad;

	assign b0 = word[7:0];
	assign b1 = word[15:8];
	assign b2 = word[23:16];
	assign b3 = word[31:24];

	// Running offset and the shared compares of this word
	assign actual    = {1'b0, offset_q} + LB1'(WORD_BYTES);
	assign overflow  = actual[LB];
	assign partial   = (bytes_valid != FULL_WORD);
	assign walk_en   = !overflow && !sticky_q && !partial;
	assign rel       = offset_q - op_start_q;
	assign room      = declared_q - op_start_q;
	assign avail     = declared_q - offset_q;
	assign shape     = opcode_shape(b0);
	assign slot_hit  = (slot_q != 3'd0) && (rel == LB'({slot_q, 2'b00}));
	assign size_bad  = (word < WORD_BITS'(op_min_q)) || (word[1:0] != 2'b00) ||
		(word > WORD_BITS'(room));
	assign size_end  = op_start_q + word[LB-1:0];
	assign start_end = offset_q + LB'(shape.minimum);
	assign end_sel   = slot_hit ? size_end : op_end_q;
	assign start_bad = (declared_q < offset_q) || (avail < LB'(WORD_BYTES)) ||
		!shape.legal || (LB'(shape.minimum) > avail);
	assign len_bad   = ({1'b0, word} > 33'(LEN_MAX)) ||
		(word < WORD_BITS'(HEADER_BYTES)) ||
		(ops_left_q > ((word - WORD_BITS'(HEADER_BYTES)) >> 2));

	// Next state for one word
	always_comb begin
		offset_d   = overflow ? offset_q : actual[LB-1:0];
		declared_d = declared_q;
		op_start_d = op_start_q;
		op_end_d   = op_end_q;
		ops_left_d = ops_left_q;
		op_min_d   = op_min_q;
		slot_d     = slot_q;
		in_op_d    = in_op_q;
		walk_err   = 1'b0;
		if (walk_en) begin
			if (offset_q == LB'(OFF_IDENT)) begin
				if (b0 != MAGIC_BYTE0 || b1 != MAGIC_BYTE1 ||
						b2 != geometry.chip_gen || b3 != geometry.tile_rows)
					walk_err = 1'b1;
			end else if (offset_q == LB'(OFF_GEOMETRY)) begin
				if (b0 != geometry.tile_columns || b1 != geometry.memory_tile_rows ||
						b2 != 8'd0 || b3 != 8'd0)
					walk_err = 1'b1;
			end else if (offset_q == LB'(OFF_COUNT)) begin
				ops_left_d = word;
			end else if (offset_q == LB'(OFF_LENGTH)) begin
				declared_d = word[LB-1:0];
				op_end_d   = LB'(HEADER_BYTES);
				walk_err   = len_bad;
			end else if (in_op_q) begin
				// Inside an operation: pick up its size word, close it at its end
				if (slot_hit && size_bad) begin
					walk_err = 1'b1;
				end else begin
					op_end_d = end_sel;
					if (actual == {1'b0, end_sel})
						in_op_d = 1'b0;
				end
			end else if (ops_left_q != '0 && offset_q == op_end_q) begin
				// Opcode word of the next operation
				if (start_bad) begin
					walk_err = 1'b1;
				end else begin
					ops_left_d = ops_left_q - WORD_BITS'(1);
					op_start_d = offset_q;
					op_min_d   = shape.minimum;
					slot_d     = shape.slot;
					op_end_d   = start_end;
					in_op_d    = (shape.minimum != 6'(WORD_BYTES));
				end
			end
		end
		sticky_d = sticky_q | partial | overflow | walk_err;
	end

	// End-of-transaction checks on the last word
	assign verdict.valid   = step && last;
	assign verdict.invalid = sticky_d || (actual < LB1'(HEADER_BYTES)) ||
		({1'b0, declared_d} != actual) || (ops_left_d != '0) || in_op_d ||
		({1'b0, op_end_d} != actual);

	// Advance on each word, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			declared_q <= '0;
			op_start_q <= '0;
			op_end_q   <= '0;
			ops_left_q <= '0;
			op_min_q   <= '0;
			slot_q     <= '0;
			in_op_q    <= 1'b0;
			sticky_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				offset_q   <= '0;
				declared_q <= '0;
				op_start_q <= '0;
				op_end_q   <= '0;
				ops_left_q <= '0;
				op_min_q   <= '0;
				slot_q     <= '0;
				in_op_q    <= 1'b0;
				sticky_q   <= 1'b0;
			end else begin
				offset_q   <= offset_d;
				declared_q <= declared_d;
				op_start_q <= op_start_d;
				op_end_q   <= op_end_d;
				ops_left_q <= ops_left_d;
				op_min_q   <= op_min_d;
				slot_q     <= slot_d;
				in_op_q    <= in_op_d;
				sticky_q   <= sticky_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/csv_result.sv =====
// ----------------------------------------------------------------------------
// Status result stage
// Encodes the verdict into a status and holds it until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_result import csv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire csv_verdict_t  verdict,
	input  wire logic          version_ok,
	output logic               free,
	csv_out_if.source          rsp
);

	logic        valid_q;
	csv_status_t status_q;
	csv_status_t status_d;

	// Unsupported version wins over every other error
	always_comb begin
		if (!version_ok)
			status_d = STATUS_UNSUPPORTED;
		else if (verdict.invalid)
			status_d = STATUS_INVALID;
		else
			status_d = STATUS_OK;
	end

	assign free = !valid_q || rsp.ready;

	// Hold the status while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= verdict.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && verdict.valid) begin
			status_q <= status_d;
		end
	end

	assign rsp.valid  = valid_q;
	assign rsp.status = status_q;

endmodule

`default_nettype wire

// ===== rtl/command_stream_validator.sv =====
// Path: a last word that transfers on cmd goes to the input register; its status then moves
//   to the result register, which drives rsp, when that is free; a stalled status delays it.
// Throughput: one command word per cycle; only a stalled status with a last word
//   waiting behind it holds cmd.ready low.
// Reset: arst_n clears the configuration registers, the walk state and both
//   valid flags at once.
`default_nettype none

`include "command_stream_validator_defines.svh"

module command_stream_validator import csv_pkg::*; #(
	parameter logic [31:0] SUPPORTED_VERSION = 32'd1,
	parameter int unsigned LENGTH_BITS       = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WORD_BITS-1:0]      cfg_wdata,
	csv_in_if.sink                         cmd,
	csv_out_if.source                      rsp
);

	csv_geometry_t        geometry_q;
	logic [WORD_BITS-1:0] format_version_q;
	logic                 version_ok;

	logic                 v_s1_q;
	logic [WORD_BITS-1:0] word_s1;
	logic                 last_s1;
	logic [BV_BITS-1:0]   bv_s1;
	logic                 s1_adv, out_free;
	csv_verdict_t         verdict;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geometry_q       <= '0;
			format_version_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHIP_GEN:          geometry_q.chip_gen          <= cfg_wdata[7:0];
				REG_TILE_ROWS:         geometry_q.tile_rows         <= cfg_wdata[7:0];
				REG_TILE_COLUMNS:      geometry_q.tile_columns      <= cfg_wdata[7:0];
				REG_MEMORY_TILE_ROWS:  geometry_q.memory_tile_rows  <= cfg_wdata[7:0];
				REG_FORMAT_VERSION:    format_version_q             <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign version_ok = (format_version_q == SUPPORTED_VERSION);

	// Input register: advance unless a last word waits on a full result stage
	assign s1_adv    = v_s1_q && (!last_s1 || out_free);
	assign cmd.ready = !v_s1_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (cmd.ready) begin
			v_s1_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			word_s1 <= cmd.word;
			last_s1 <= cmd.last;
			bv_s1   <= cmd.bytes_valid;
		end
	end

	csv_walk #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_adv),
		.word        (word_s1),
		.last        (last_s1),
		.bytes_valid (bv_s1),
		.geometry    (geometry_q),
		.verdict     (verdict)
	);

	csv_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.verdict    (verdict),
		.version_ok (version_ok),
		.free       (out_free),
		.rsp        (rsp)
	);

	// A verdict always lands in the result register
	`CSV_ASSERT_NEXT(a_verdict_to_status, clk, arst_n, verdict.valid, rsp.valid)
	// No verdict while the held status is stalled
	`CSV_ASSERT_SAME(a_no_overwrite, clk, arst_n, rsp.valid && !rsp.ready, !verdict.valid)
	// Back-pressure only from a last word stuck behind a stalled status
	`CSV_ASSERT_SAME(a_stall_cause, clk, arst_n, !cmd.ready,
		v_s1_q && last_s1 && rsp.valid && !rsp.ready)

endmodule

`default_nettype wire

// ===== test/command_stream_validator_test.sv =====
// ----------------------------------------------------------------------------
// Command stream validator testbench
// Streams command transactions into the validator and checks every status.
// A short directed set opens the run, then random transactions follow, most
// of them well formed and the rest with one deliberate defect each, under
// several register settings. A scoreboard predicts each status from the
// accepted words and compares it with what the block returns.
// ----------------------------------------------------------------------------

module command_stream_validator_test;
	import csv_pkg::*;

	localparam logic [31:0] VERSION_SUPPORTED = 32'd1;
	localparam int unsigned CLK_HALF          = 6;
	localparam int unsigned DRAIN_CYCLES      = 8;
	localparam int unsigned HOLD_CYCLES       = 400;
	localparam int unsigned RUN_LIMIT         = 3000000;
	localparam logic [32:0] LENGTH_CAP        = 33'h0_FFFF_FFFF;

	// Opcode shapes: minimum size in bytes and size word slot (0 for none)
	localparam int unsigned BASIC_OPCODES        = 14;
	localparam logic [7:0]  EXTENDED_OPCODE_BASE = 8'd128;
	localparam logic [7:0]  TOP_OPCODE           = 8'hFF;
	localparam logic [5:0]  EXTENDED_MINIMUM     = 6'd8;
	localparam logic [2:0]  EXTENDED_SLOT        = 3'd1;
	localparam logic [BASIC_OPCODES-1:0][5:0] OPCODE_MINIMUM = {
		6'd4, 6'd12, 6'd8, 6'd16, 6'd8, 6'd16, 6'd32,
		6'd4, 6'd4, 6'd32, 6'd28, 6'd16, 6'd16, 6'd24
	};
	localparam logic [BASIC_OPCODES-1:0][2:0] OPCODE_SLOT = {
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6,
		3'd0, 3'd0, 3'd6, 3'd6, 3'd0, 3'd3, 3'd5
	};

	typedef enum int {
		CMD_CLEAN,
		CMD_BAD_MAGIC,
		CMD_BAD_GEOMETRY,
		CMD_BAD_RESERVED,
		CMD_BAD_COUNT,
		CMD_BAD_LENGTH,
		CMD_BAD_SIZE,
		CMD_BAD_OPCODE,
		CMD_TRAILING,
		CMD_TRUNCATED,
		CMD_PARTIAL,
		CMD_SHORT,
		CMD_NOISE
	} command_fault_t;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_EVERY_THIRD
	} stall_mode_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 last;
		logic [BV_BITS-1:0]   bytes_valid;
	} command_beat_t;

	// Status predictor and store of expected statuses
	class status_scoreboard;
		csv_geometry_t geometry;
		logic [31:0]   version;
		logic [31:0]   byte_offset, declared_length, ops_left, op_start, op_end;
		logic [5:0]    op_minimum;
		logic [2:0]    size_slot;
		bit            in_op;
		bit            bad;
		csv_status_t   expected_status [$];
		int unsigned   errors;
		int unsigned   checked;

		function new();
			geometry = '0;
			version  = '0;
			errors   = 0;
			checked  = 0;
			clear_walk();
		endfunction

		function void clear_walk();
			byte_offset     = '0;
			declared_length = '0;
			ops_left        = '0;
			op_start        = '0;
			op_end          = '0;
			op_minimum      = '0;
			size_slot       = '0;
			in_op           = 1'b0;
			bad             = 1'b0;
		endfunction

		function void write_reg(csv_reg_t idx, logic [31:0] value);
			case (idx)
				REG_CHIP_GEN:          geometry.chip_gen          = value[7:0];
				REG_TILE_ROWS:         geometry.tile_rows         = value[7:0];
				REG_TILE_COLUMNS:      geometry.tile_columns      = value[7:0];
				REG_MEMORY_TILE_ROWS:  geometry.memory_tile_rows  = value[7:0];
				REG_FORMAT_VERSION:    version                    = value;
				default: ;
			endcase
		endfunction

		// Advance the walk by one accepted word; queue a status on the last one
		function void note_word(logic [31:0] w, logic fin, logic [BV_BITS-1:0] bv);
			logic [32:0] actual;
			logic [31:0] off;
			logic [5:0]  need;
			logic [2:0]  slot;
			bit          legal;

			off    = byte_offset;
			actual = {1'b0, off} + 33'd4;
			if (bv != FULL_WORD)
				bad = 1'b1;
			if (actual > LENGTH_CAP) begin
				bad = 1'b1;
			end else begin
				if (!bad) begin
					if (off == OFF_IDENT) begin
						if (w[7:0] != MAGIC_BYTE0 || w[15:8] != MAGIC_BYTE1 ||
						    w[23:16] != geometry.chip_gen ||
						    w[31:24] != geometry.tile_rows)
							bad = 1'b1;
					end else if (off == OFF_GEOMETRY) begin
						if (w[7:0] != geometry.tile_columns ||
						    w[15:8] != geometry.memory_tile_rows || w[31:16] != 16'h0)
							bad = 1'b1;
					end else if (off == OFF_COUNT) begin
						ops_left = w;
					end else if (off == OFF_LENGTH) begin
						declared_length = w;
						if (w < HEADER_BYTES || ops_left > (w - HEADER_BYTES) / WORD_BYTES)
							bad = 1'b1;
						op_end = HEADER_BYTES;
					end else if (in_op) begin
						// size word: check against the minimum and the room left
						if (size_slot != 0 && off - op_start == 32'(size_slot) * WORD_BYTES) begin
							if (w < op_minimum || w[1:0] != 2'b00 ||
							    w > declared_length - op_start)
								bad = 1'b1;
							else
								op_end = op_start + w;
						end
						if (actual == {1'b0, op_end})
							in_op = 1'b0;
					end else if (ops_left != 0 && off == op_end) begin
						// opcode word: look up the shape of the operation
						legal = 1'b1;
						need  = '0;
						slot  = '0;
						if (w[7:0] >= EXTENDED_OPCODE_BASE) begin
							need = EXTENDED_MINIMUM;
							slot = EXTENDED_SLOT;
						end else if (w[7:0] < BASIC_OPCODES) begin
							need = OPCODE_MINIMUM[w[3:0]];
							slot = OPCODE_SLOT[w[3:0]];
						end else begin
							legal = 1'b0;
						end
						if (declared_length < off || declared_length - off < WORD_BYTES ||
						    !legal || need > declared_length - off) begin
							bad = 1'b1;
						end else begin
							ops_left   = ops_left - 1;
							op_start   = off;
							op_minimum = need;
							size_slot  = slot;
							op_end     = off + need;
							in_op      = (actual != {1'b0, op_end});
						end
					end
				end
				byte_offset = actual[31:0];
			end

			if (fin) begin
				if (!bad && (actual < HEADER_BYTES || {1'b0, declared_length} != actual ||
				    ops_left != 0 || in_op || {1'b0, op_end} != actual))
					bad = 1'b1;
				if (version != VERSION_SUPPORTED)
					expected_status.push_back(STATUS_UNSUPPORTED);
				else
					expected_status.push_back(bad ? STATUS_INVALID : STATUS_OK);
				clear_walk();
			end
		endfunction

		function void check_status(logic [1:0] got);
			csv_status_t want;
			checked++;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: unexpected status transfer, expected none, actual %0d",
				         $time, got);
				return;
			end
			want = expected_status.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: status mismatch, expected %s (%0d), actual %0d",
				         $time, want.name(), want, got);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [WORD_BITS-1:0]      cfg_wdata;

	csv_in_if  cmd_if ();
	csv_out_if rsp_if ();

	status_scoreboard board = new();
	command_beat_t    outgoing [$];
	int unsigned      burst_left = 0;

	command_stream_validator #(
		.SUPPORTED_VERSION(VERSION_SUPPORTED),
		.LENGTH_BITS      (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_if),
		.rsp      (rsp_if)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Feed the predictor with every word transfer
	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready)
			board.note_word(cmd_if.word, cmd_if.last, cmd_if.bytes_valid);
	end

	// Check every status transfer
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			board.check_status(rsp_if.status);
	end

	function automatic logic [31:0] ident_word();
		return {board.geometry.tile_rows, board.geometry.chip_gen,
		        MAGIC_BYTE1, MAGIC_BYTE0};
	endfunction

	function automatic logic [31:0] geometry_word();
		return {16'h0, board.geometry.memory_tile_rows, board.geometry.tile_columns};
	endfunction

	function automatic void queue_word(logic [31:0] w, logic fin, logic [BV_BITS-1:0] bv);
		command_beat_t beat;
		beat.word        = w;
		beat.last        = fin;
		beat.bytes_valid = bv;
		outgoing.push_back(beat);
	endfunction

	task automatic write_cfg(csv_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		board.write_reg(idx, value);
		@(posedge clk);
	endtask

	// Write all registers; upper bits of the byte registers carry junk
	task automatic configure(input logic [7:0] gen, input logic [7:0] rows,
	                         input logic [7:0] cols, input logic [7:0] mem_rows,
	                         input logic [31:0] version);
		write_cfg(REG_CHIP_GEN,          {24'($urandom()), gen});
		write_cfg(REG_TILE_ROWS,         {24'($urandom()), rows});
		write_cfg(REG_TILE_COLUMNS,      {24'($urandom()), cols});
		write_cfg(REG_MEMORY_TILE_ROWS,  {24'($urandom()), mem_rows});
		write_cfg(REG_FORMAT_VERSION,    version);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer queued words in bursts separated by random gaps
	task automatic send_queued();
		command_beat_t beat;
		while (outgoing.size() != 0) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 6)) begin
					@(negedge clk);
					cmd_if.valid       <= 1'b0;
					cmd_if.word        <= $urandom();
					cmd_if.last        <= 1'($urandom_range(0, 1));
					cmd_if.bytes_valid <= 3'($urandom_range(0, 7));
				end
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				                                        : $urandom_range(1, 12);
			end
			beat = outgoing.pop_front();
			@(negedge clk);
			cmd_if.valid       <= 1'b1;
			cmd_if.word        <= beat.word;
			cmd_if.last        <= beat.last;
			cmd_if.bytes_valid <= beat.bytes_valid;
			@(posedge clk);
			while (!cmd_if.ready)
				@(posedge clk);
			burst_left--;
		end
	endtask

	// Drop valid and wait until every status has come back
	task automatic settle();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (board.expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Build one transaction, well formed apart from the chosen defect
	task automatic build_command(input command_fault_t fault);
		logic [31:0]        words [$];
		logic [31:0]        r, size;
		logic [7:0]         opc;
		logic [5:0]         need;
		logic [2:0]         slot;
		logic [BV_BITS-1:0] bv;
		int unsigned        op_count, size_at, opcode_at, pick, cut, partial_at;

		words     = {ident_word(), geometry_word(), 32'h0, 32'h0};
		op_count  = $urandom_range(0, 5);
		size_at   = 0;
		opcode_at = 0;
		if ((fault == CMD_BAD_SIZE || fault == CMD_BAD_OPCODE) && op_count == 0)
			op_count = 1;

		for (int i = 0; i < op_count; i++) begin
			if ((fault == CMD_BAD_SIZE && i == 0) || $urandom_range(0, 3) == 0)
				opc = EXTENDED_OPCODE_BASE | 8'($urandom_range(0, 127));
			else
				opc = 8'($urandom_range(0, BASIC_OPCODES - 1));
			if (opc >= EXTENDED_OPCODE_BASE) begin
				need = EXTENDED_MINIMUM;
				slot = EXTENDED_SLOT;
			end else begin
				need = OPCODE_MINIMUM[opc[3:0]];
				slot = OPCODE_SLOT[opc[3:0]];
			end
			size = need;
			if (slot != 0)
				size = need + WORD_BYTES * (($urandom_range(0, 19) == 0) ?
				                            $urandom_range(0, 60) : $urandom_range(0, 4));
			if (i == 0)
				opcode_at = words.size();
			if (slot != 0 && size_at == 0)
				size_at = words.size() + slot;
			r = $urandom();
			words.push_back({r[31:8], opc});
			for (int k = 1; k < size / WORD_BYTES; k++)
				words.push_back((k == slot) ? size : $urandom());
		end
		words[2] = op_count;
		words[3] = words.size() * WORD_BYTES;

		case (fault)
			CMD_BAD_MAGIC:
				words[0][15:0] ^= 16'($urandom_range(1, 16'hFFFF));
			CMD_BAD_GEOMETRY: begin
				r    = 32'($urandom_range(1, 255));
				pick = $urandom_range(0, 3);
				case (pick)
					0:       words[0][23:16] ^= r[7:0];
					1:       words[0][31:24] ^= r[7:0];
					2:       words[1][7:0]   ^= r[7:0];
					default: words[1][15:8]  ^= r[7:0];
				endcase
			end
			CMD_BAD_RESERVED:
				words[1][31:16] ^= 16'($urandom_range(1, 16'hFFFF));
			CMD_BAD_COUNT: begin
				pick = $urandom_range(0, 2);
				if (pick == 0)
					words[2] = $urandom();
				else if (pick == 1 && op_count != 0)
					words[2] = op_count - 1;
				else
					words[2] = op_count + $urandom_range(1, 3);
			end
			CMD_BAD_LENGTH: begin
				pick = $urandom_range(0, 2);
				if (pick == 0)
					words[3] = $urandom();
				else if (pick == 1)
					words[3] = words[3] + WORD_BYTES * $urandom_range(1, 3);
				else
					words[3] = words[3] - WORD_BYTES * $urandom_range(1, 3);
			end
			CMD_BAD_SIZE: begin
				pick = $urandom_range(0, 3);
				case (pick)
					0:       words[size_at] ^= 32'($urandom_range(1, 3));
					1:       words[size_at] = WORD_BYTES * $urandom_range(0, 1);
					2:       words[size_at] = $urandom() | 32'h8000_0000;
					default: words[size_at] = words[size_at] + WORD_BYTES * $urandom_range(1, 8);
				endcase
			end
			CMD_BAD_OPCODE:
				words[opcode_at][7:0] = 8'($urandom_range(BASIC_OPCODES,
				                                          EXTENDED_OPCODE_BASE - 1));
			CMD_TRAILING: begin
				repeat ($urandom_range(1, 3))
					words.push_back($urandom());
				words[3] = words.size() * WORD_BYTES;
			end
			CMD_TRUNCATED: begin
				cut = $urandom_range(1, words.size() - 1);
				repeat (cut)
					void'(words.pop_back());
			end
			CMD_SHORT: begin
				cut = $urandom_range(1, 3);
				while (words.size() > cut)
					void'(words.pop_back());
			end
			CMD_NOISE: begin
				words.delete();
				repeat ($urandom_range(1, 8))
					words.push_back($urandom());
			end
			default: ;
		endcase

		// A partial word may land anywhere, the last word included
		partial_at = (fault == CMD_PARTIAL) ? $urandom_range(0, words.size() - 1)
		                                    : words.size();
		foreach (words[i]) begin
			bv = FULL_WORD;
			if (i == partial_at) begin
				pick = $urandom_range(0, 6);
				bv   = (pick >= FULL_WORD) ? BV_BITS'(pick + 1) : BV_BITS'(pick);
			end
			queue_word(words[i], i == words.size() - 1, bv);
		end
	endtask

	// Status receiver: stall patterns in random spans, two long hold-offs
	initial begin : status_receiver
		stall_mode_t mode;
		int unsigned span, beat, next_hold, holds;
		rsp_if.ready = 1'b0;
		beat      = 0;
		holds     = 0;
		next_hold = 40;
		forever begin
			if (holds < 2 && board.checked >= next_hold) begin
				// hold off so that the word path backs up behind a pending status
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					rsp_if.ready <= 1'b0;
				end
				holds++;
				next_hold = board.checked + 300;
			end
			mode = stall_mode_t'($urandom_range(READY_ALWAYS, READY_EVERY_THIRD));
			span = $urandom_range(4, 64);
			repeat (span) begin
				@(negedge clk);
				beat++;
				case (mode)
					READY_ALWAYS: rsp_if.ready <= 1'b1;
					READY_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
					READY_SPARSE: rsp_if.ready <= ($urandom_range(0, 4) == 0);
					default:      rsp_if.ready <= (beat % 3 == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int unsigned    sent, budget;
		command_fault_t fault;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_CHIP_GEN;
		cfg_wdata          = '0;
		cmd_if.valid       = 1'b0;
		cmd_if.word        = '0;
		cmd_if.last        = 1'b0;
		cmd_if.bytes_valid = FULL_WORD;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed transactions
		configure(8'hA7, 8'h00, 8'hFF, 8'h3C, VERSION_SUPPORTED);
		// header only, no operations
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b0, FULL_WORD);
		queue_word(32'h0, 1'b0, FULL_WORD);
		queue_word(HEADER_BYTES, 1'b1, FULL_WORD);
		// stream shorter than a header
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b1, FULL_WORD);
		// partial final word
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b0, FULL_WORD);
		queue_word(32'h0, 1'b0, FULL_WORD);
		queue_word(HEADER_BYTES, 1'b1, 3'd3);
		// trailing word after the header, no operations
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b0, FULL_WORD);
		queue_word(32'h0, 1'b0, FULL_WORD);
		queue_word(32'd20, 1'b0, FULL_WORD);
		queue_word(32'hFFFF_FFFF, 1'b1, FULL_WORD);
		// one extended operation at its minimum size
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b0, FULL_WORD);
		queue_word(32'd1, 1'b0, FULL_WORD);
		queue_word(32'd24, 1'b0, FULL_WORD);
		queue_word({24'hA5A5A5, TOP_OPCODE}, 1'b0, FULL_WORD);
		queue_word(32'd8, 1'b1, FULL_WORD);
		// declared length beyond the actual stream
		queue_word(ident_word(), 1'b0, FULL_WORD);
		queue_word(geometry_word(), 1'b0, FULL_WORD);
		queue_word(32'h0, 1'b0, FULL_WORD);
		queue_word(32'd20, 1'b1, FULL_WORD);
		send_queued();
		settle();

		// Random transactions under several register settings
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: configure(8'h00, 8'h00, 8'h00, 8'h00, VERSION_SUPPORTED);
				1: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, VERSION_SUPPORTED);
				2: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
				             8'($urandom()), 32'h0);
				3: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
				             8'($urandom()), 32'hFFFF_FFFF);
				default: configure(8'($urandom()), 8'($urandom()), 8'($urandom()),
				                   8'($urandom()), VERSION_SUPPORTED);
			endcase
			budget = (phase == 2 || phase == 3) ? 150 : 550;
			sent   = 0;
			while (sent < budget) begin
				if ($urandom_range(0, 99) < 60)
					fault = CMD_CLEAN;
				else
					fault = command_fault_t'($urandom_range(CMD_BAD_MAGIC, CMD_NOISE));
				build_command(fault);
				sent += outgoing.size();
				send_queued();
			end
			settle();
		end

		if (board.errors == 0 && board.expected_status.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("%0t: run limit reached", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/csv_pkg.sv
rtl/csv_in_if.sv
rtl/csv_out_if.sv
rtl/csv_walk.sv
rtl/csv_result.sv
rtl/command_stream_validator.sv
test/command_stream_validator_test.sv
